/* hw/rtl/rpa_pkg.sv */
// rpa_pkg: shared types, register indexes and saturation helpers for the
// rotate-about-axis block. No dependencies.
package rpa_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_Z  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 3'd5;

    localparam logic signed [31:0] ORIGIN_RST     = 32'sd65536;
    localparam logic [31:0]        TRIG_UNIT_RST  = 32'h4000_0000;
    localparam logic [31:0]        STEP_TRIG_RST  = 32'h3EB9_0CB7;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [16:0] TRIG_ONE = 17'sd16384;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic [31:0]        align_z_trig;
        logic [31:0]        align_y_trig;
        logic [31:0]        step_trig;
    } cfg_t;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31])
            r = v[32] ? S32_MIN : S32_MAX;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
        logic signed [31:0] r;
        if ((&v[35:31]) || !(|v[35:31]))
            r = v[31:0];
        else
            r = v[35] ? S32_MIN : S32_MAX;
        return r;
    endfunction

endpackage

/* hw/rtl/rpa_point_if.sv */
// rpa_point_if: request channel carrying one input point (Q16.16).
// Depends on nothing.
interface rpa_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    output ready);
endinterface

/* hw/rtl/rpa_result_if.sv */
// rpa_result_if: result channel carrying one rotated point (Q16.16).
// Depends on nothing.
interface rpa_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] rotated_x;
    logic signed [31:0] rotated_y;
    logic signed [31:0] rotated_z;

    modport source (output valid, output rotated_x, output rotated_y, output rotated_z,
                    input ready);
    modport sink   (input valid, input rotated_x, input rotated_y, input rotated_z,
                    output ready);
endinterface

/* hw/rtl/rpa_cfg_regs.sv */
// rpa_cfg_regs: configuration register file, write-only port.
// Depends on rpa_pkg.
module rpa_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rpa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output rpa_pkg::cfg_t                   cfg
);
    import rpa_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ORIGIN_X: cfg_next.origin_x     = $signed(cfg_wdata);
                CFG_ORIGIN_Y: cfg_next.origin_y     = $signed(cfg_wdata);
                CFG_ORIGIN_Z: cfg_next.origin_z     = $signed(cfg_wdata);
                CFG_ALIGN_Z:  cfg_next.align_z_trig = cfg_wdata;
                CFG_ALIGN_Y:  cfg_next.align_y_trig = cfg_wdata;
                CFG_STEP:     cfg_next.step_trig    = cfg_wdata;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x     <= ORIGIN_RST;
            cfg_reg.origin_y     <= ORIGIN_RST;
            cfg_reg.origin_z     <= ORIGIN_RST;
            cfg_reg.align_z_trig <= TRIG_UNIT_RST;
            cfg_reg.align_y_trig <= TRIG_UNIT_RST;
            cfg_reg.step_trig    <= STEP_TRIG_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

    a_origin_x_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == CFG_ORIGIN_X) |=> cfg_reg.origin_x == $past(cfg_wdata))
        else $error("origin x write lost");

endmodule

/* hw/rtl/rpa_rot_stage.sv */
// rpa_rot_stage: one plane rotation a' = a*c - b*s, b' = a*s + b*c, two stages:
// products, then sum, floor shift by 14 and saturation. Third coordinate passes.
// Depends on rpa_pkg.
module rpa_rot_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               v_in,
    input  logic signed [31:0] a_in,
    input  logic signed [31:0] b_in,
    input  logic signed [31:0] p_in,
    input  logic signed [16:0] cos_q,
    input  logic signed [16:0] sin_q,
    output logic               v_out,
    output logic signed [31:0] a_out,
    output logic signed [31:0] b_out,
    output logic signed [31:0] p_out
);
    import rpa_pkg::*;

    logic               v1_reg, v2_reg;
    logic signed [48:0] ac_reg, bs_reg, as_reg, bc_reg;
    logic signed [48:0] ac_next, bs_next, as_next, bc_next;
    logic signed [31:0] p1_reg, p2_reg;
    logic signed [31:0] a2_reg, b2_reg;
    logic signed [31:0] a2_next, b2_next;
    logic signed [49:0] a_sum, b_sum;

    assign ac_next = a_in * cos_q;
    assign bs_next = b_in * sin_q;
    assign as_next = a_in * sin_q;
    assign bc_next = b_in * cos_q;

    assign a_sum = {ac_reg[48], ac_reg} - {bs_reg[48], bs_reg};
    assign b_sum = {as_reg[48], as_reg} + {bc_reg[48], bc_reg};
    assign a2_next = sat36(a_sum[49:14]);
    assign b2_next = sat36(b_sum[49:14]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= v_in;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ac_reg <= ac_next;
            bs_reg <= bs_next;
            as_reg <= as_next;
            bc_reg <= bc_next;
            p1_reg <= p_in;
            a2_reg <= a2_next;
            b2_reg <= b2_next;
            p2_reg <= p1_reg;
        end
    end

    assign v_out = v2_reg;
    assign a_out = a2_reg;
    assign b_out = b2_reg;
    assign p_out = p2_reg;

    // identity trig pair must return the coordinates of a valid request unchanged
    a_identity_a: assert property (@(posedge clk) disable iff (!rst_n)
        (en && $past(en) && v1_reg && $past(cos_q == TRIG_ONE && sin_q == 17'sd0))
        |=> a_out == $past(a_in, 2))
        else $error("identity rotation altered a");

    a_identity_b: assert property (@(posedge clk) disable iff (!rst_n)
        (en && $past(en) && v1_reg && $past(cos_q == TRIG_ONE && sin_q == 17'sd0))
        |=> b_out == $past(b_in, 2))
        else $error("identity rotation altered b");

endmodule

/* hw/rtl/rotate_point_about_axis_core.sv */
// rotate_point_about_axis_core: rotates a Q16.16 point about an arbitrary axis.
// Pipeline: origin subtract, five rotations of two stages each, origin add.
// Throughput one point per cycle; one global enable stalls every stage together.
// Reset (async, active low) empties the pipeline and loads the default registers.
// Depends on rpa_pkg, rpa_point_if, rpa_result_if, rpa_cfg_regs, rpa_rot_stage.
module rotate_point_about_axis_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rpa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    rpa_point_if.sink                       point,
    rpa_result_if.source                    result
);
    import rpa_pkg::*;

    cfg_t cfg;

    logic en;

    logic signed [16:0] cz, sz, nsz, cy, sy, nsy, ct, st;

    logic               v0_reg;
    logic signed [31:0] x0_reg, y0_reg, z0_reg;
    logic signed [31:0] x0_next, y0_next, z0_next;

    logic               v1, v2, v3, v4, v5;
    logic signed [31:0] x1, y1, z1, x2, y2, z2, x3, y3, z3, x4, y4, z4, x5, y5, z5;

    logic               vo_reg;
    logic signed [31:0] xo_reg, yo_reg, zo_reg;
    logic signed [31:0] xo_next, yo_next, zo_next;

    rpa_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign en = !vo_reg || result.ready;
    assign point.ready = en;

    assign cz  = {cfg.align_z_trig[31], cfg.align_z_trig[31:16]};
    assign sz  = {cfg.align_z_trig[15], cfg.align_z_trig[15:0]};
    assign cy  = {cfg.align_y_trig[31], cfg.align_y_trig[31:16]};
    assign sy  = {cfg.align_y_trig[15], cfg.align_y_trig[15:0]};
    assign ct  = {cfg.step_trig[31], cfg.step_trig[31:16]};
    assign st  = {cfg.step_trig[15], cfg.step_trig[15:0]};
    assign nsz = -sz;
    assign nsy = -sy;

    assign x0_next = sat33({point.point_x[31], point.point_x} -
                           {cfg.origin_x[31], cfg.origin_x});
    assign y0_next = sat33({point.point_y[31], point.point_y} -
                           {cfg.origin_y[31], cfg.origin_y});
    assign z0_next = sat33({point.point_z[31], point.point_z} -
                           {cfg.origin_z[31], cfg.origin_z});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= point.valid;
            vo_reg <= v5;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg <= x0_next;
            y0_reg <= y0_next;
            z0_reg <= z0_next;
            xo_reg <= xo_next;
            yo_reg <= yo_next;
            zo_reg <= zo_next;
        end
    end

    // align about Z: (a,b) = (x,y)
    rpa_rot_stage u_rot_az (
        .clk (clk), .rst_n (rst_n), .en (en), .v_in (v0_reg),
        .a_in (x0_reg), .b_in (y0_reg), .p_in (z0_reg), .cos_q (cz), .sin_q (sz),
        .v_out (v1), .a_out (x1), .b_out (y1), .p_out (z1)
    );

    // align about Y: (a,b) = (x,z), sine negated
    rpa_rot_stage u_rot_ay (
        .clk (clk), .rst_n (rst_n), .en (en), .v_in (v1),
        .a_in (x1), .b_in (z1), .p_in (y1), .cos_q (cy), .sin_q (nsy),
        .v_out (v2), .a_out (x2), .b_out (z2), .p_out (y2)
    );

    // rotation step about Z
    rpa_rot_stage u_rot_st (
        .clk (clk), .rst_n (rst_n), .en (en), .v_in (v2),
        .a_in (x2), .b_in (y2), .p_in (z2), .cos_q (ct), .sin_q (st),
        .v_out (v3), .a_out (x3), .b_out (y3), .p_out (z3)
    );

    // undo Y alignment
    rpa_rot_stage u_rot_uy (
        .clk (clk), .rst_n (rst_n), .en (en), .v_in (v3),
        .a_in (x3), .b_in (z3), .p_in (y3), .cos_q (cy), .sin_q (sy),
        .v_out (v4), .a_out (x4), .b_out (z4), .p_out (y4)
    );

    // undo Z alignment
    rpa_rot_stage u_rot_uz (
        .clk (clk), .rst_n (rst_n), .en (en), .v_in (v4),
        .a_in (x4), .b_in (y4), .p_in (z4), .cos_q (cz), .sin_q (nsz),
        .v_out (v5), .a_out (x5), .b_out (y5), .p_out (z5)
    );

    assign xo_next = sat33({x5[31], x5} + {cfg.origin_x[31], cfg.origin_x});
    assign yo_next = sat33({y5[31], y5} + {cfg.origin_y[31], cfg.origin_y});
    assign zo_next = sat33({z5[31], z5} + {cfg.origin_z[31], cfg.origin_z});

    assign result.valid     = vo_reg;
    assign result.rotated_x = xo_reg;
    assign result.rotated_y = yo_reg;
    assign result.rotated_z = zo_reg;

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> $stable({v0_reg, v1, v2, v3, v4, v5}))
        else $error("pipeline moved during output stall");

endmodule

/* dv/rpa_rotation_checker.sv */
// rpa_rotation_checker: watches the register port and both point channels, predicts
// each rotated point from its own register copy and compares field by field.
// Depends on rpa_pkg, rpa_point_if, rpa_result_if.
module rpa_rotation_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpa_pkg::CFG_DATA_W-1:0] cfg_wdata,
    rpa_point_if                           point,
    rpa_result_if                          result,
    output int unsigned                    pending,
    output int unsigned                    checked,
    output int unsigned                    errors
);
    timeunit 1ns;
    timeprecision 1ps;

    import rpa_pkg::*;

    localparam int unsigned MAX_SHOWN = 30;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } coord_t;

    cfg_t        regs;
    coord_t      rotated_q[$];
    int unsigned check_n;
    int unsigned err_n;
    int unsigned shown;

    function automatic logic signed [31:0] clamp32(input longint v);
        logic signed [31:0] r;
        if (v > longint'(S32_MAX))
            r = S32_MAX;
        else if (v < longint'(S32_MIN))
            r = S32_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    // two Q16.16 x Q1.14 products, floor shift by 14, saturate
    function automatic longint rot_term(input longint a, input longint ca,
                                        input longint b, input longint cb);
        longint s;
        s = (a * ca + b * cb) >>> 14;
        return longint'(clamp32(s));
    endfunction

    function automatic longint trig_cos(input logic [31:0] w);
        return longint'($signed(w[31:16]));
    endfunction

    function automatic longint trig_sin(input logic [31:0] w);
        return longint'($signed(w[15:0]));
    endfunction

    function automatic coord_t rotate_about_axis(input cfg_t c, input coord_t p);
        longint ox, oy, oz;
        longint cz, sz, cy, sy, ct, st;
        longint x, y, z, nx, ny, nz;
        coord_t r;
        ox = longint'(c.origin_x);
        oy = longint'(c.origin_y);
        oz = longint'(c.origin_z);
        cz = trig_cos(c.align_z_trig);
        sz = trig_sin(c.align_z_trig);
        cy = trig_cos(c.align_y_trig);
        sy = trig_sin(c.align_y_trig);
        ct = trig_cos(c.step_trig);
        st = trig_sin(c.step_trig);
        x = longint'(clamp32(longint'(p.x) - ox));
        y = longint'(clamp32(longint'(p.y) - oy));
        z = longint'(clamp32(longint'(p.z) - oz));
        nx = rot_term(x, cz, y, -sz);
        ny = rot_term(x, sz, y, cz);
        x = nx;
        y = ny;
        nx = rot_term(z, sy, x, cy);
        nz = rot_term(z, cy, x, -sy);
        x = nx;
        z = nz;
        nx = rot_term(x, ct, y, -st);
        ny = rot_term(x, st, y, ct);
        x = nx;
        y = ny;
        nx = rot_term(z, -sy, x, cy);
        nz = rot_term(z, cy, x, sy);
        x = nx;
        z = nz;
        nx = rot_term(x, cz, y, sz);
        ny = rot_term(x, -sz, y, cz);
        r.x = clamp32(nx + ox);
        r.y = clamp32(ny + oy);
        r.z = clamp32(z + oz);
        return r;
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (want !== got)
        begin
            err_n++;
            if (shown < MAX_SHOWN)
            begin
                shown++;
                $display("%0t ns: rotated_%s mismatch, expected %0d (%h), actual %0d (%h)",
                         $time, name, want, want, got, got);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs <= '{origin_x: ORIGIN_RST, origin_y: ORIGIN_RST, origin_z: ORIGIN_RST,
                      align_z_trig: TRIG_UNIT_RST, align_y_trig: TRIG_UNIT_RST,
                      step_trig: STEP_TRIG_RST};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ORIGIN_X: regs.origin_x     <= cfg_wdata;
                CFG_ORIGIN_Y: regs.origin_y     <= cfg_wdata;
                CFG_ORIGIN_Z: regs.origin_z     <= cfg_wdata;
                CFG_ALIGN_Z:  regs.align_z_trig <= cfg_wdata;
                CFG_ALIGN_Y:  regs.align_y_trig <= cfg_wdata;
                CFG_STEP:     regs.step_trig    <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        coord_t got;
        coord_t want;
        coord_t req;
        if (!rst_n)
        begin
            rotated_q.delete();
            check_n = 0;
            err_n   = 0;
            shown   = 0;
            pending <= 0;
            checked <= 0;
            errors  <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                got.x = result.rotated_x;
                got.y = result.rotated_y;
                got.z = result.rotated_z;
                if (rotated_q.size() == 0)
                begin
                    err_n++;
                    if (shown < MAX_SHOWN)
                    begin
                        shown++;
                        $display("%0t ns: unexpected result, expected none, actual %h %h %h",
                                 $time, got.x, got.y, got.z);
                    end
                end
                else
                begin
                    want = rotated_q.pop_front();
                    check_n++;
                    check_field("x", want.x, got.x);
                    check_field("y", want.y, got.y);
                    check_field("z", want.z, got.z);
                end
            end
            if (point.valid && point.ready)
            begin
                req.x = point.point_x;
                req.y = point.point_y;
                req.z = point.point_z;
                rotated_q.push_back(rotate_about_axis(regs, req));
            end
            pending <= rotated_q.size();
            checked <= check_n;
            errors  <= err_n;
        end
    end

endmodule

/* dv/tb_rotate_point_about_axis_core.sv */
// tb_rotate_point_about_axis_core: drives points and register settings into the
// rotate-about-axis core under random stalls and gives the verdict.
// Depends on rpa_pkg, rpa_point_if, rpa_result_if, rpa_rotation_checker and the core.
module tb_rotate_point_about_axis_core;
    timeunit 1ns;
    timeprecision 1ps;

    import rpa_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned PHASES       = 12;
    localparam int unsigned PHASE_POINTS = 100;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    rpa_point_if  point_ch();
    rpa_result_if result_ch();

    int unsigned pending;
    int unsigned checked;
    int unsigned errors;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned cycles        = 0;
    int unsigned sent          = 0;
    int unsigned settings_n    = 0;

    rotate_point_about_axis_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .point     (point_ch),
        .result    (result_ch)
    );

    rpa_rotation_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .point     (point_ch),
        .result    (result_ch),
        .pending   (pending),
        .checked   (checked),
        .errors    (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("** rotate_point_about_axis_core: FAILED **");
            $finish;
        end
    end

    task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
                              input logic signed [31:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            point_ch.valid <= 1'b0;
            @(posedge clk);
        end
        point_ch.valid   <= 1'b1;
        point_ch.point_x <= x;
        point_ch.point_y <= y;
        point_ch.point_z <= z;
        @(posedge clk);
        while (!point_ch.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic wait_drained();
        point_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic apply_settings(input cfg_t c);
        write_reg(CFG_ORIGIN_X, c.origin_x);
        write_reg(CFG_ORIGIN_Y, c.origin_y);
        write_reg(CFG_ORIGIN_Z, c.origin_z);
        write_reg(CFG_ALIGN_Z, c.align_z_trig);
        write_reg(CFG_ALIGN_Y, c.align_y_trig);
        write_reg(CFG_STEP, c.step_trig);
        // writes past the last register must be ignored
        if ($urandom_range(1))
            write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, $urandom);
        cfg_we <= 1'b0;
        settings_n++;
    endtask

    function automatic cfg_t make_settings(input logic signed [31:0] org,
                                           input logic [31:0] trig);
        cfg_t c;
        c.origin_x     = org;
        c.origin_y     = org;
        c.origin_z     = org;
        c.align_z_trig = trig;
        c.align_y_trig = trig;
        c.step_trig    = trig;
        return c;
    endfunction

    function automatic logic signed [31:0] pick_coord();
        logic signed [31:0] v;
        case ($urandom_range(11))
            0:       v = S32_MAX;
            1:       v = S32_MIN;
            2:       v = -32'sd1;
            3, 4:    v = $urandom;
            default: v = $signed($urandom_range(32'h0080_0000)) - 32'sh0040_0000;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_trig();
        logic [31:0] w;
        real         a;
        int          c;
        int          s;
        case ($urandom_range(9))
            0:       w = $urandom;
            1:       w = {$urandom_range(1) ? 16'h7FFF : 16'h8000,
                          $urandom_range(1) ? 16'h7FFF : 16'h8000};
            2:       w = TRIG_UNIT_RST;
            default:
            begin
                a = $urandom_range(62831) / 10000.0;
                c = $rtoi($cos(a) * 16384.0);
                s = $rtoi($sin(a) * 16384.0);
                w = {c[15:0], s[15:0]};
            end
        endcase
        return w;
    endfunction

    function automatic cfg_t random_settings();
        cfg_t c;
        c.origin_x     = pick_coord();
        c.origin_y     = pick_coord();
        c.origin_z     = pick_coord();
        c.align_z_trig = pick_trig();
        c.align_y_trig = pick_trig();
        c.step_trig    = pick_trig();
        return c;
    endfunction

    initial
    begin
        int unsigned pause_at;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_wdata         = '0;
        point_ch.valid    = 1'b0;
        point_ch.point_x  = '0;
        point_ch.point_y  = '0;
        point_ch.point_z  = '0;
        result_ch.ready   = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 26;
        recv_idle_pct = 50;

        // reset settings, including the unit points {1,1,1} and {4,1,2}
        send_point(32'sd0, 32'sd0, 32'sd0);
        send_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
        send_point(32'sh0004_0000, 32'sh0001_0000, 32'sh0002_0000);
        send_point(S32_MAX, S32_MAX, S32_MAX);
        send_point(S32_MIN, S32_MIN, S32_MIN);
        send_point(S32_MAX, S32_MIN, -32'sd1);
        wait_drained();

        // full-scale origin, sine at its most negative value
        apply_settings(make_settings(S32_MIN, 32'h7FFF_8000));
        send_point(S32_MAX, S32_MAX, S32_MAX);
        send_point(S32_MIN, S32_MIN, S32_MIN);
        send_point(32'sd0, 32'sd0, 32'sd0);
        send_point(S32_MAX, 32'sd0, S32_MIN);
        wait_drained();

        apply_settings(make_settings(S32_MAX, 32'h8000_7FFF));
        send_point(S32_MIN, S32_MIN, S32_MIN);
        send_point(S32_MAX, S32_MAX, S32_MAX);
        send_point(32'sd0, 32'sd0, 32'sd0);
        send_point(S32_MIN, S32_MAX, 32'sd0);
        wait_drained();

        // non-unit trig pairs, used without normalization
        apply_settings(make_settings(32'sd0, 32'h8000_8000));
        send_point(S32_MAX, S32_MAX, S32_MAX);
        send_point(S32_MIN, S32_MIN, S32_MIN);
        send_point(S32_MAX, S32_MIN, S32_MAX);
        wait_drained();

        apply_settings(make_settings(32'sd0, 32'h0000_0000));
        send_point(S32_MAX, S32_MIN, S32_MAX);
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < PHASES / 3)
            begin
                send_idle_pct = 26;
                recv_idle_pct = 50;
            end
            else if (p < 2 * PHASES / 3)
            begin
                send_idle_pct = 50;
                recv_idle_pct = 26;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            apply_settings(random_settings());
            pause_at = $urandom_range(90, 10);
            for (int i = 0; i < PHASE_POINTS; i++)
            begin
                if (i == pause_at)
                    wait_drained();
                send_point(pick_coord(), pick_coord(), pick_coord());
            end
            wait_drained();
        end

        repeat (24) @(posedge clk);
        $display("%0d points sent, %0d rotated points checked over %0d register settings",
                 sent, checked, settings_n);
        $display("stall mixes: sender-heavy, receiver-heavy and none; full-scale origins and trig");
        if (errors == 0)
            $display("** rotate_point_about_axis_core: PASSED **");
        else
            $display("** rotate_point_about_axis_core: FAILED **");
        $finish;
    end

endmodule
